// ===== rtl/core/kts_pkg.sv =====
// Shared types, character codes, token codes and keyword lookup for the token scanner.
package kts_pkg;

    localparam int MAX_LEXEME_DEF = 63;
    localparam int KW_CHARS       = 8;
    localparam int KW_BITS        = KW_CHARS * 8;
    localparam int LINE_W         = 16;
    localparam int TOK_W          = 6;

    typedef logic [TOK_W-1:0] t_tok;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_WORD    = 8'b0000_0010,
        M_NUM     = 8'b0000_0100,
        M_MINUS   = 8'b0000_1000,
        M_COMMENT = 8'b0001_0000,
        M_COLON   = 8'b0010_0000,
        M_GT      = 8'b0100_0000,
        M_LT      = 8'b1000_0000
    } t_mode;

    localparam t_tok TOK_BEGIN     = 6'd0;
    localparam t_tok TOK_END       = 6'd1;
    localparam t_tok TOK_READ      = 6'd2;
    localparam t_tok TOK_WRITE     = 6'd3;
    localparam t_tok TOK_IF        = 6'd4;
    localparam t_tok TOK_THEN      = 6'd5;
    localparam t_tok TOK_ELSE      = 6'd6;
    localparam t_tok TOK_ENDIF     = 6'd7;
    localparam t_tok TOK_WHILE     = 6'd8;
    localparam t_tok TOK_ENDWHILE  = 6'd9;
    localparam t_tok TOK_ID        = 6'd10;
    localparam t_tok TOK_INT       = 6'd11;
    localparam t_tok TOK_FALSEOP   = 6'd12;
    localparam t_tok TOK_TRUEOP    = 6'd13;
    localparam t_tok TOK_NULLOP    = 6'd14;
    localparam t_tok TOK_LPAREN    = 6'd15;
    localparam t_tok TOK_RPAREN    = 6'd16;
    localparam t_tok TOK_SEMI      = 6'd17;
    localparam t_tok TOK_COMMA     = 6'd18;
    localparam t_tok TOK_ASSIGN    = 6'd19;
    localparam t_tok TOK_PLUS      = 6'd20;
    localparam t_tok TOK_MINUS     = 6'd21;
    localparam t_tok TOK_MULT      = 6'd22;
    localparam t_tok TOK_DIV       = 6'd23;
    localparam t_tok TOK_NOT       = 6'd24;
    localparam t_tok TOK_LESS      = 6'd25;
    localparam t_tok TOK_LESSEQ    = 6'd26;
    localparam t_tok TOK_GREATER   = 6'd27;
    localparam t_tok TOK_GREATEREQ = 6'd28;
    localparam t_tok TOK_EQUAL     = 6'd29;
    localparam t_tok TOK_NOTEQ     = 6'd30;
    localparam t_tok TOK_SCANEOF   = 6'd31;
    localparam t_tok TOK_ERROR     = 6'd32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // The word register holds the first character in the highest used byte,
    // which lines up with how string literals pack.
    function automatic t_tok kw_lookup(input logic [KW_BITS-1:0] word);
        t_tok code;
        unique case (word)
            64'("BEGIN"):    code = TOK_BEGIN;
            64'("END"):      code = TOK_END;
            64'("READ"):     code = TOK_READ;
            64'("WRITE"):    code = TOK_WRITE;
            64'("IF"):       code = TOK_IF;
            64'("THEN"):     code = TOK_THEN;
            64'("ELSE"):     code = TOK_ELSE;
            64'("ENDIF"):    code = TOK_ENDIF;
            64'("WHILE"):    code = TOK_WHILE;
            64'("ENDWHILE"): code = TOK_ENDWHILE;
            64'("FALSEOP"):  code = TOK_FALSEOP;
            64'("TRUEOP"):   code = TOK_TRUEOP;
            64'("NULLOP"):   code = TOK_NULLOP;
            default:         code = TOK_ID;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/keyword_token_scanner.sv =====
// Top level of the keyword token scanner: input register, scan logic, result queue.
// A character passes through the input register and then the result queue before it appears as a token.
// Throughput: one character per cycle while the result queue has room for two more tokens;
// a character that yields two tokens takes two queue slots, and a four-entry result queue absorbs that burst.
// Reset (i_rst_n, synchronous, active low) empties the queue, sets the scan mode to
// idle, clears the word and length, sets the line counter to one and clears end state.
module keyword_token_scanner
    import kts_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF,
    parameter int LEN_W      = $clog2(MAX_LEXEME + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char_code,
    input  logic             i_end_of_input,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [TOK_W-1:0] o_token_code,
    output logic [LEN_W-1:0] o_lexeme_length,
    output logic [LINE_W-1:0] o_line_number,
    output logic             o_last_of_run
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoi;

    // Scanner state
    t_mode              r_mode, n_mode;
    logic [KW_BITS-1:0] r_word, n_word;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_long, n_long;
    logic [LINE_W-1:0]  r_line, n_line;
    logic               r_fin, n_fin;

    // Result queue
    t_tok              r_q_code [QDEPTH];
    logic [LEN_W-1:0]  r_q_len  [QDEPTH];
    logic [LINE_W-1:0] r_q_line [QDEPTH];
    logic              r_q_last [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_qcnt;

    logic go, pop;
    logic is_letter, is_digit;
    logic [7:0] up_char;
    logic [LEN_W-1:0] cnt_inc;

    // Pending token of the current mode
    logic fl_v;
    t_tok fl_code;
    logic [LEN_W-1:0] fl_len;

    // Result of scanning the character from idle
    t_mode st_mode;
    logic st_v;
    t_tok st_code;
    logic [LEN_W-1:0] st_cnt;
    logic [KW_BITS-1:0] st_word;
    logic st_line;

    logic a_v, b_v, restart, line_inc;
    t_tok a_code, b_code;
    logic [LEN_W-1:0] a_len, b_len;

    logic s0_v, s1_v, s0_last;
    t_tok s0_code, s1_code;
    logic [LEN_W-1:0] s0_len, s1_len;
    logic [QPTR_W:0] push_n;

    assign go      = r_in_valid && (r_qcnt <= (QPTR_W+1)'(QDEPTH - 2));
    assign o_ready = !r_in_valid || go;
    assign o_valid = (r_qcnt != '0);
    assign pop     = o_valid && i_ready;

    assign o_token_code    = r_q_code[r_rd];
    assign o_lexeme_length = r_q_len[r_rd];
    assign o_line_number   = r_q_line[r_rd];
    assign o_last_of_run   = r_q_last[r_rd];

    assign is_letter = ((r_char >= 8'd65) && (r_char <= 8'd90)) ||
                       ((r_char >= 8'd97) && (r_char <= 8'd122));
    assign is_digit  = (r_char >= 8'd48) && (r_char <= 8'd57);
    assign up_char   = (r_char >= 8'd97) ? (r_char - 8'd32) : r_char;
    assign cnt_inc   = (r_cnt < LEN_W'(MAX_LEXEME)) ? (r_cnt + LEN_W'(1)) : r_cnt;

    always_comb begin
        fl_v    = 1'b1;
        fl_code = TOK_ERROR;
        fl_len  = LEN_W'(1);
        unique case (r_mode)
            M_WORD: begin
                fl_code = r_long ? TOK_ID : kw_lookup(r_word);
                fl_len  = r_cnt;
            end
            M_NUM: begin
                fl_code = TOK_INT;
                fl_len  = r_cnt;
            end
            M_MINUS: fl_code = TOK_MINUS;
            M_COLON: fl_code = TOK_ERROR;
            M_GT:    fl_code = TOK_GREATER;
            M_LT:    fl_code = TOK_LESS;
            default: fl_v = 1'b0;
        endcase
    end

    always_comb begin
        st_mode = M_IDLE;
        st_v    = 1'b0;
        st_code = TOK_ERROR;
        st_cnt  = '0;
        st_word = '0;
        st_line = 1'b0;
        if (is_letter) begin
            st_mode = M_WORD;
            st_cnt  = LEN_W'(1);
            st_word = KW_BITS'(up_char);
        end else if (is_digit) begin
            st_mode = M_NUM;
            st_cnt  = LEN_W'(1);
        end else begin
            unique case (r_char)
                CH_MINUS: begin
                    st_mode = M_MINUS;
                    st_cnt  = LEN_W'(1);
                end
                CH_COLON:                 st_mode = M_COLON;
                CH_GT:                    st_mode = M_GT;
                CH_LT:                    st_mode = M_LT;
                CH_SPACE, CH_TAB, CH_NUL: st_v = 1'b0;
                CH_LF:                    st_line = 1'b1;
                CH_LPAREN: begin st_v = 1'b1; st_code = TOK_LPAREN; end
                CH_RPAREN: begin st_v = 1'b1; st_code = TOK_RPAREN; end
                CH_SEMI:   begin st_v = 1'b1; st_code = TOK_SEMI;   end
                CH_COMMA:  begin st_v = 1'b1; st_code = TOK_COMMA;  end
                CH_PLUS:   begin st_v = 1'b1; st_code = TOK_PLUS;   end
                CH_STAR:   begin st_v = 1'b1; st_code = TOK_MULT;   end
                CH_SLASH:  begin st_v = 1'b1; st_code = TOK_DIV;    end
                CH_BANG:   begin st_v = 1'b1; st_code = TOK_NOT;    end
                CH_EQ:     begin st_v = 1'b1; st_code = TOK_EQUAL;  end
                default:   begin st_v = 1'b1; st_code = TOK_ERROR;  end
            endcase
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_word   = r_word;
        n_cnt    = r_cnt;
        n_long   = r_long;
        n_line   = r_line;
        n_fin    = r_fin;
        a_v      = 1'b0;
        a_code   = fl_code;
        a_len    = fl_len;
        b_v      = 1'b0;
        b_code   = st_code;
        b_len    = LEN_W'(1);
        restart  = 1'b0;
        line_inc = 1'b0;
        if (go && !r_fin) begin
            if (r_eoi) begin
                a_v    = fl_v;
                b_v    = 1'b1;
                b_code = TOK_SCANEOF;
                b_len  = '0;
                n_mode = M_IDLE;
                n_word = '0;
                n_cnt  = '0;
                n_long = 1'b0;
                n_fin  = 1'b1;
            end else begin
                unique case (r_mode)
                    M_WORD: begin
                        if (is_letter || is_digit) begin
                            if (r_cnt < LEN_W'(KW_CHARS)) begin
                                n_word = {r_word[KW_BITS-9:0], up_char};
                            end else begin
                                n_long = 1'b1;
                            end
                            n_cnt = cnt_inc;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    M_NUM: begin
                        if (is_digit) n_cnt = cnt_inc;
                        else restart = 1'b1;
                    end
                    M_MINUS: begin
                        if (r_char == CH_MINUS) begin
                            n_mode = M_COMMENT;
                        end else if (is_digit) begin
                            n_mode = M_NUM;
                            n_cnt  = cnt_inc;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (r_char == CH_LF) begin
                            n_mode   = M_IDLE;
                            n_cnt    = '0;
                            line_inc = 1'b1;
                        end
                    end
                    M_COLON: begin
                        if (r_char == CH_EQ) begin
                            a_v    = 1'b1;
                            a_code = TOK_ASSIGN;
                            a_len  = LEN_W'(2);
                            n_mode = M_IDLE;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    M_GT: begin
                        if (r_char == CH_EQ) begin
                            a_v    = 1'b1;
                            a_code = TOK_GREATEREQ;
                            a_len  = LEN_W'(2);
                            n_mode = M_IDLE;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    M_LT: begin
                        if (r_char == CH_EQ) begin
                            a_v    = 1'b1;
                            a_code = TOK_LESSEQ;
                            a_len  = LEN_W'(2);
                            n_mode = M_IDLE;
                        end else if (r_char == CH_GT) begin
                            a_v    = 1'b1;
                            a_code = TOK_NOTEQ;
                            a_len  = LEN_W'(2);
                            n_mode = M_IDLE;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    default: restart = 1'b1;
                endcase
                // The ending character is scanned again as if from idle.
                if (restart) begin
                    a_v      = fl_v;
                    b_v      = st_v;
                    n_mode   = st_mode;
                    n_word   = st_word;
                    n_cnt    = st_cnt;
                    n_long   = 1'b0;
                    line_inc = st_line;
                end
                if (line_inc && (r_line != {LINE_W{1'b1}})) begin
                    n_line = r_line + LINE_W'(1);
                end
            end
        end
    end

    // Pack the up to two tokens of this character into consecutive queue slots.
    always_comb begin
        s0_v    = a_v || b_v;
        s1_v    = a_v && b_v;
        s0_code = a_v ? a_code : b_code;
        s0_len  = a_v ? a_len : b_len;
        s0_last = !s1_v;
        s1_code = b_code;
        s1_len  = b_len;
        push_n  = (QPTR_W+1)'(s0_v) + (QPTR_W+1)'(s1_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_word     <= '0;
            r_cnt      <= '0;
            r_long     <= 1'b0;
            r_line     <= LINE_W'(1);
            r_fin      <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_qcnt     <= '0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            r_mode <= n_mode;
            r_word <= n_word;
            r_cnt  <= n_cnt;
            r_long <= n_long;
            r_line <= n_line;
            r_fin  <= n_fin;
            r_wr   <= r_wr + push_n[QPTR_W-1:0];
            if (pop) r_rd <= r_rd + QPTR_W'(1);
            r_qcnt <= r_qcnt + push_n - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_code;
            r_eoi  <= i_end_of_input;
        end
        if (s0_v) begin
            r_q_code[r_wr] <= s0_code;
            r_q_len[r_wr]  <= s0_len;
            r_q_line[r_wr] <= r_line;
            r_q_last[r_wr] <= s0_last;
        end
        if (s1_v) begin
            r_q_code[r_wr + QPTR_W'(1)] <= s1_code;
            r_q_len[r_wr + QPTR_W'(1)]  <= s1_len;
            r_q_line[r_wr + QPTR_W'(1)] <= r_line;
            r_q_last[r_wr + QPTR_W'(1)] <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/kts_checker.sv =====
// Port-level checker for the keyword token scanner, with its bind statement.
module kts_checker
    import kts_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF,
    parameter int LEN_W      = $clog2(MAX_LEXEME + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [7:0]        i_char_code,
    input logic              i_end_of_input,
    input logic              o_valid,
    input logic              i_ready,
    input logic [TOK_W-1:0]  o_token_code,
    input logic [LEN_W-1:0]  o_lexeme_length,
    input logic [LINE_W-1:0] o_line_number,
    input logic              o_last_of_run
);

    // A stalled transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_code) &&
            $stable(o_lexeme_length) && $stable(o_line_number) && $stable(o_last_of_run))
        else $error("output changed while stalled");

    // End of scan closes the run and carries no lexeme.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_code == TOK_SCANEOF) |-> o_last_of_run && (o_lexeme_length == '0))
        else $error("end token malformed");

    // Nothing follows the end token until reset.
    a_eof_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_token_code == TOK_SCANEOF) |=> !o_valid)
        else $error("token after end of scan");

    // Codes stay in range and lines never read zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_code <= TOK_ERROR) && (o_line_number != '0))
        else $error("token code or line out of range");

    // Line numbers never go backward between consecutive tokens.
    a_line_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready ##1 o_valid |-> o_line_number >= $past(o_line_number))
        else $error("line number went backward");

endmodule

bind keyword_token_scanner kts_checker #(.MAX_LEXEME(MAX_LEXEME), .LEN_W(LEN_W)) u_kts_checker (.*);
